### sv/assert_macros.svh
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert an implication on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Assert that the consequent holds in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### sv/pgn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgn_pkg
// Types, widths and helpers for the 2D gradient noise block.
// ----------------------------------------------------------------------------
package pgn_pkg;
    localparam int GRID_WIDTH_DEF  = 256;
    localparam int GRID_HEIGHT_DEF = 256;
    localparam int CRD_W  = 24;
    localparam int GRD_W  = 16;
    localparam int NODE_W = 9;
    localparam int OUT_W  = 16;
    localparam int FRAC_W = 8;
    localparam int DOT_W  = 28;   // two products of 16x10 bits plus a carry
    localparam int FADE_W = 25;   // fade in Q0.24 fits in 0..2^24
    localparam int BLD_W  = 52;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic [NODE_W-1:0]       grid_col;
        logic [NODE_W-1:0]       grid_row;
        logic signed [GRD_W-1:0] grad_x;
        logic signed [GRD_W-1:0] grad_y;
        logic signed [CRD_W-1:0] point_x;
        logic signed [CRD_W-1:0] point_y;
    } t_req;

    typedef struct packed {
        logic signed [OUT_W-1:0] noise_value;
    } t_rsp;

    // fade(f) = 3*f^2*256 - 2*f^3, f in Q0.8, result in Q0.24 (<= 2^24)
    function automatic logic [24:0] fade_f(input logic [FRAC_W-1:0] f);
        logic [15:0] f2;
        logic [23:0] f3;
        logic [25:0] a;
        begin
            f2 = 16'(f) * 16'(f);
            f3 = 24'(f2) * 24'(f);
            a  = 26'(f2) * 26'd768;
            fade_f = 25'(a - 26'({f3, 1'b0}));
        end
    endfunction
endpackage

### sv/pgn_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgn_req_if / pgn_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface pgn_req_if;
    import pgn_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface pgn_rsp_if;
    import pgn_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### sv/pgn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgn_front
// Accepts requests, wraps query coordinates and splits them into cell and
// fraction, and queues classified operations for the back end.
// ----------------------------------------------------------------------------
module pgn_front #(
    parameter int GRID_WIDTH  = pgn_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = pgn_pkg::GRID_HEIGHT_DEF,
    parameter int CW = $clog2(GRID_WIDTH + 2),
    parameter int CH = $clog2(GRID_HEIGHT + 2)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    pgn_req_if.sink                s_req,
    output logic                   o_op_valid,
    input  logic                   i_op_ready,
    output logic                   o_op_wr,
    output logic [CW-1:0]          o_op_col,
    output logic [CH-1:0]          o_op_row,
    output logic [2*pgn_pkg::GRD_W-1:0] o_op_grad,
    output logic [pgn_pkg::FRAC_W-1:0]  o_op_fx,
    output logic [pgn_pkg::FRAC_W-1:0]  o_op_fy
);
    import pgn_pkg::*;
    `include "assert_macros.svh"

    localparam int QD = 4;
    localparam int OPW = 1 + CW + CH + 2*GRD_W + 2*FRAC_W;
    localparam int IW = CRD_W - FRAC_W;

    // Integer part mod size: offset to unsigned, take the residue by a
    // reciprocal multiply, then remove the offset's own residue.
    localparam int XS = IW + $clog2(GRID_WIDTH);
    localparam int XM = ((1 << XS) + GRID_WIDTH - 1) / GRID_WIDTH;
    localparam int XK = (1 << (IW - 1)) % GRID_WIDTH;
    localparam int YS = IW + $clog2(GRID_HEIGHT);
    localparam int YM = ((1 << YS) + GRID_HEIGHT - 1) / GRID_HEIGHT;
    localparam int YK = (1 << (IW - 1)) % GRID_HEIGHT;

    function automatic logic [CW-1:0] wrapx(input logic signed [IW-1:0] ip);
        logic [IW-1:0]  u;
        logic [IW+18:0] p;
        logic [IW-1:0]  q;
        logic [IW-1:0]  r;
        begin
            u = {~ip[IW-1], ip[IW-2:0]};
            p = (IW+19)'(u) * (IW+19)'(XM);
            q = IW'(p >> XS);
            r = u - IW'(32'(q) * GRID_WIDTH);
            if (r < IW'(XK)) r = r + IW'(GRID_WIDTH - XK);
            else r = r - IW'(XK);
            wrapx = CW'(r);
        end
    endfunction
    function automatic logic [CH-1:0] wrapy(input logic signed [IW-1:0] ip);
        logic [IW-1:0]  u;
        logic [IW+18:0] p;
        logic [IW-1:0]  q;
        logic [IW-1:0]  r;
        begin
            u = {~ip[IW-1], ip[IW-2:0]};
            p = (IW+19)'(u) * (IW+19)'(YM);
            q = IW'(p >> YS);
            r = u - IW'(32'(q) * GRID_HEIGHT);
            if (r < IW'(YK)) r = r + IW'(GRID_HEIGHT - YK);
            else r = r - IW'(YK);
            wrapy = CH'(r);
        end
    endfunction

    logic [OPW-1:0] r_q [QD];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       push, pop, ok;
    logic [CW-1:0] col;
    logic [CH-1:0] row;
    t_req rq;

    assign rq = s_req.payload;
    assign s_req.ready = (r_cnt != 3'(QD));
    assign push = s_req.valid && s_req.ready && ok;
    assign pop  = o_op_valid && i_op_ready;
    assign o_op_valid = (r_cnt != 3'd0);

    always_comb begin
        ok = 1'b1;
        if (rq.req_type == REQ_QUERY) begin
            col = wrapx(rq.point_x[CRD_W-1:FRAC_W]);
            row = wrapy(rq.point_y[CRD_W-1:FRAC_W]);
        end else begin
            col = CW'(rq.grid_col);
            row = CH'(rq.grid_row);
            // drop writes outside the table
            if (32'(rq.grid_col) > 32'(GRID_WIDTH) ||
                32'(rq.grid_row) > 32'(GRID_HEIGHT)) ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(push) - 3'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push)
            r_q[r_wp] <= {rq.req_type == REQ_WRITE, col, row,
                          rq.grad_y, rq.grad_x,
                          rq.point_x[FRAC_W-1:0], rq.point_y[FRAC_W-1:0]};
    end

    assign {o_op_wr, o_op_col, o_op_row, o_op_grad, o_op_fx, o_op_fy} = r_q[r_rp];

    `ASSERT_IMPL(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= 3'(QD))
    `ASSERT_NEXT(a_full_blk, i_clk, i_rst_n, r_cnt == 3'(QD) && !pop,
                 r_cnt == 3'(QD))
    `ASSERT_IMPL(a_ptr, i_clk, i_rst_n, r_cnt == 3'd0, r_wp == r_rp)
endmodule

### sv/pgn_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgn_back
// Gradient store banked by node parity, corner dot products and the two
// fade blends as a stall-free pipeline with a skid buffer at the output.
// ----------------------------------------------------------------------------
module pgn_back #(
    parameter int GRID_WIDTH  = pgn_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = pgn_pkg::GRID_HEIGHT_DEF,
    parameter int CW = $clog2(GRID_WIDTH + 2),
    parameter int CH = $clog2(GRID_HEIGHT + 2)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_op_valid,
    output logic                   o_op_ready,
    input  logic                   i_op_wr,
    input  logic [CW-1:0]          i_op_col,
    input  logic [CH-1:0]          i_op_row,
    input  logic [2*pgn_pkg::GRD_W-1:0] i_op_grad,
    input  logic [pgn_pkg::FRAC_W-1:0]  i_op_fx,
    input  logic [pgn_pkg::FRAC_W-1:0]  i_op_fy,
    pgn_rsp_if.source              m_rsp
);
    import pgn_pkg::*;
    `include "assert_macros.svh"

    localparam int BC = (GRID_WIDTH + 2) / 2;
    localparam int BR = (GRID_HEIGHT + 2) / 2;
    localparam int BD = BC * BR;
    localparam int AW = $clog2(BD);
    localparam int NST = 6;
    localparam int SKD = NST + 2;
    localparam int DW = 2*GRD_W;

    logic [DW-1:0] r_mem0 [BD];
    logic [DW-1:0] r_mem1 [BD];
    logic [DW-1:0] r_mem2 [BD];
    logic [DW-1:0] r_mem3 [BD];

    logic [NST-1:0] r_v;
    logic [NST-1:0] n_v;
    logic acc;

    // credit: never launch more than the output fifo can hold
    logic [3:0] r_cred;
    assign o_op_ready = (r_cred != 4'd0) || i_op_wr;
    assign acc = i_op_valid && o_op_ready;

    // bank b = (col parity, row parity); address = (col/2)*BR + row/2
    function automatic logic [AW-1:0] baddr(input logic [CW-1:0] c,
                                            input logic [CH-1:0] r);
        baddr = AW'(32'(c >> 1) * BR + 32'(r >> 1));
    endfunction

    logic [CW-1:0] c1;
    logic [CH-1:0] r1;
    logic [AW-1:0] a00, a01, a10, a11, wa;
    logic [1:0] wb;
    assign c1 = i_op_col + CW'(1);
    assign r1 = i_op_row + CH'(1);
    assign wa = baddr(i_op_col, i_op_row);
    assign wb = {i_op_col[0], i_op_row[0]};
    // corner addresses for bank by parity
    logic [AW-1:0] ab [4];
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            logic [CW-1:0] cc;
            logic [CH-1:0] rr;
            cc = (i_op_col[0] == b[1]) ? i_op_col : c1;
            rr = (i_op_row[0] == b[0]) ? i_op_row : r1;
            ab[b] = baddr(cc, rr);
        end
    end
    assign a00 = ab[0]; assign a01 = ab[1]; assign a10 = ab[2]; assign a11 = ab[3];

    logic [DW-1:0] r_rd [4];
    always_ff @(posedge i_clk) begin
        if (acc && i_op_wr && wb == 2'd0) r_mem0[wa] <= i_op_grad;
        if (acc && i_op_wr && wb == 2'd1) r_mem1[wa] <= i_op_grad;
        if (acc && i_op_wr && wb == 2'd2) r_mem2[wa] <= i_op_grad;
        if (acc && i_op_wr && wb == 2'd3) r_mem3[wa] <= i_op_grad;
        r_rd[0] <= r_mem0[a00];
        r_rd[1] <= r_mem1[a01];
        r_rd[2] <= r_mem2[a10];
        r_rd[3] <= r_mem3[a11];
    end

    // stage 1 tags
    logic [FRAC_W-1:0] r1_fx, r1_fy;
    logic [1:0] r1_par;
    always_ff @(posedge i_clk) begin
        r1_fx <= i_op_fx; r1_fy <= i_op_fy;
        r1_par <= {i_op_col[0], i_op_row[0]};
    end

    // stage 2: corner dot products. corner k: bit1 = +x, bit0 = +y
    logic signed [DW/2-1:0] gx [4], gy [4];
    logic signed [DOT_W-1:0] r2_d [4];
    logic [24:0] r2_sx, r2_sy;
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            logic [1:0] bk;
            bk = {r1_par[1] ^ k[1], r1_par[0] ^ k[0]};
            gx[k] = r_rd[bk][GRD_W-1:0];
            gy[k] = r_rd[bk][DW-1:GRD_W];
        end
    end
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            logic signed [9:0] dx, dy;
            dx = k[1] ? $signed({2'b11, r1_fx}) : $signed({2'b00, r1_fx});
            dy = k[0] ? $signed({2'b11, r1_fy}) : $signed({2'b00, r1_fy});
            r2_d[k] <= DOT_W'(gx[k] * dx) + DOT_W'(gy[k] * dy);
        end
        r2_sx <= fade_f(r1_fx);
        r2_sy <= fade_f(r1_fy);
    end

    // stage 3: x blend products
    logic signed [BLD_W-1:0] r3_pa, r3_pb;
    logic signed [DOT_W-1:0] r3_s, r3_u;
    logic [24:0] r3_sy;
    always_ff @(posedge i_clk) begin
        r3_pa <= BLD_W'($signed({1'b0, r2_sx}) * $signed(r2_d[2] - r2_d[0]));
        r3_pb <= BLD_W'($signed({1'b0, r2_sx}) * $signed(r2_d[3] - r2_d[1]));
        r3_s <= r2_d[0]; r3_u <= r2_d[1]; r3_sy <= r2_sy;
    end

    // stage 4: round x blends to Q.22
    logic signed [BLD_W-1:0] ta, tb;
    logic signed [DOT_W-1:0] r4_a, r4_b;
    logic [24:0] r4_sy;
    assign ta = (BLD_W'(r3_s) <<< 24) + r3_pa + BLD_W'(1 << 23);
    assign tb = (BLD_W'(r3_u) <<< 24) + r3_pb + BLD_W'(1 << 23);
    always_ff @(posedge i_clk) begin
        r4_a <= DOT_W'(ta >>> 24);
        r4_b <= DOT_W'(tb >>> 24);
        r4_sy <= r3_sy;
    end

    // stage 5: y blend product
    logic signed [BLD_W-1:0] r5_p;
    logic signed [DOT_W-1:0] r5_a;
    always_ff @(posedge i_clk) begin
        r5_p <= BLD_W'($signed({1'b0, r4_sy}) * $signed(r4_b - r4_a));
        r5_a <= r4_a;
    end

    // stage 6: round to Q.14 and saturate
    logic signed [BLD_W-1:0] ty, ry;
    logic signed [OUT_W-1:0] r6_o;
    assign ty = (BLD_W'(r5_a) <<< 24) + r5_p + BLD_W'(64'd1 << 31);
    assign ry = ty >>> 32;
    always_ff @(posedge i_clk) begin
        if (ry > BLD_W'(32767)) r6_o <= 16'sh7fff;
        else if (ry < -BLD_W'(32768)) r6_o <= 16'sh8000;
        else r6_o <= OUT_W'(ry);
    end

    // valid pipeline
    always_comb n_v = {r_v[NST-2:0], acc && !i_op_wr};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else r_v <= n_v;
    end

    // output fifo
    logic [OUT_W-1:0] r_f [SKD];
    logic [2:0] r_fw, r_fr;
    logic [3:0] r_fc;
    logic push, pop;
    assign push = r_v[NST-1];
    assign pop = m_rsp.valid && m_rsp.ready;
    assign m_rsp.valid = (r_fc != 4'd0);
    assign m_rsp.payload.noise_value = r_f[r_fr];
    always_ff @(posedge i_clk) begin
        if (push) r_f[r_fw] <= r6_o;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= '0; r_fr <= '0; r_fc <= '0; r_cred <= 4'(SKD);
        end else begin
            if (push) r_fw <= (r_fw == 3'(SKD-1)) ? 3'd0 : r_fw + 3'd1;
            if (pop) r_fr <= (r_fr == 3'(SKD-1)) ? 3'd0 : r_fr + 3'd1;
            r_fc <= r_fc + 4'(push) - 4'(pop);
            r_cred <= r_cred - 4'(acc && !i_op_wr) + 4'(pop);
        end
    end

    `ASSERT_IMPL(a_fifo_ovf, i_clk, i_rst_n, 1'b1, r_fc <= 4'(SKD))
    `ASSERT_IMPL(a_credit, i_clk, i_rst_n, 1'b1,
                 32'(r_cred) + 32'(r_fc) + 32'($countones(r_v)) == SKD)
    `ASSERT_IMPL(a_push_room, i_clk, i_rst_n, push, r_fc != 4'(SKD) || pop)
endmodule

### sv/perlin_gradient_noise_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perlin_gradient_noise_2d
// Two-dimensional gradient noise over a loadable table of gradients.
// ----------------------------------------------------------------------------
//  channel   dir   payload
//  s_req     in    req_type, grid_col, grid_row, grad_x, grad_y, point_x, point_y
//  m_rsp     out   noise_value (one beat per query, none per write)
//
// One beat per cycle sustained while results are taken; the four parity banks
// of the gradient store give all four corners in the same cycle. Writes take
// effect in the cycle they leave the front queue. The store is not cleared by
// reset. Output stalls back up through an eight-entry result buffer and a
// four-entry front queue.
module perlin_gradient_noise_2d #(
    parameter int GRID_WIDTH  = pgn_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = pgn_pkg::GRID_HEIGHT_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    pgn_req_if.sink s_req,
    pgn_rsp_if.source m_rsp
);
    import pgn_pkg::*;
    localparam int CW = $clog2(GRID_WIDTH + 2);
    localparam int CH = $clog2(GRID_HEIGHT + 2);

    logic op_valid, op_ready, op_wr;
    logic [CW-1:0] op_col;
    logic [CH-1:0] op_row;
    logic [2*GRD_W-1:0] op_grad;
    logic [FRAC_W-1:0] op_fx, op_fy;

    pgn_front #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT),
                .CW(CW), .CH(CH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_req(s_req),
        .o_op_valid(op_valid), .i_op_ready(op_ready), .o_op_wr(op_wr),
        .o_op_col(op_col), .o_op_row(op_row), .o_op_grad(op_grad),
        .o_op_fx(op_fx), .o_op_fy(op_fy));

    pgn_back #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT),
               .CW(CW), .CH(CH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_op_valid(op_valid), .o_op_ready(op_ready), .i_op_wr(op_wr),
        .i_op_col(op_col), .i_op_row(op_row), .i_op_grad(op_grad),
        .i_op_fx(op_fx), .i_op_fy(op_fy), .m_rsp(m_rsp));
endmodule

### tb/tb_perlin_gradient_noise_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_perlin_gradient_noise_2d
// Drives gradient writes and noise queries with random gaps on both sides,
// predicts each noise beat from a shadow gradient table and checks results
// in order.
// ----------------------------------------------------------------------------
module tb_perlin_gradient_noise_2d;
    import pgn_pkg::*;

    localparam int GW = GRID_WIDTH_DEF;
    localparam int GH = GRID_HEIGHT_DEF;
    localparam int ROWS = GH + 1;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    pgn_req_if req_ch ();
    pgn_rsp_if rsp_ch ();

    perlin_gradient_noise_2d dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_req(req_ch.sink), .m_rsp(rsp_ch.source)
    );

    logic [31:0] grad_table [(GW+1)*ROWS];
    bit          grad_written [(GW+1)*ROWS];
    logic signed [15:0] noise_expected [$];
    int  error_count = 0;
    int  cycle_count = 0;
    int  query_count = 0;
    bit  rsp_hold = 0;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_perlin_gradient_noise_2d: errors");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // Receiver ready: random stalls, with a no-stall mode.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (rsp_hold) begin
            rsp_ch.ready <= 1'b1;
        end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) < 65);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (noise_expected.size() == 0) begin
                $display("%0t: unexpected noise beat %0d", $time,
                         rsp_ch.payload.noise_value);
                error_count++;
            end else begin
                logic signed [15:0] exp_v;
                exp_v = noise_expected.pop_front();
                if (rsp_ch.payload.noise_value !== exp_v) begin
                    $display("%0t: noise_value expected %0d actual %0d", $time,
                             exp_v, rsp_ch.payload.noise_value);
                    error_count++;
                end
            end
        end
    end

    function automatic longint rnd_half_up(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint corner_product(int col, int row, longint dx, longint dy);
        logic [31:0] e;
        e = grad_table[col*ROWS + row];
        return longint'($signed(e[15:0])) * dx + longint'($signed(e[31:16])) * dy;
    endfunction

    function automatic logic signed [15:0] noise_at(logic [23:0] px_b, logic [23:0] py_b);
        longint px, py, fx, fy, sx, sy, s, t, u, v, a, b, r;
        int cx, cy;
        px = longint'($signed(px_b));
        py = longint'($signed(py_b));
        fx = px & 255;
        fy = py & 255;
        cx = int'((((px - fx) / 256) % GW + GW) % GW);
        cy = int'((((py - fy) / 256) % GH + GH) % GH);
        s = corner_product(cx, cy, fx, fy);
        t = corner_product(cx + 1, cy, fx - 256, fy);
        u = corner_product(cx, cy + 1, fx, fy - 256);
        v = corner_product(cx + 1, cy + 1, fx - 256, fy - 256);
        sx = 3 * fx * fx * 256 - 2 * fx * fx * fx;
        sy = 3 * fy * fy * 256 - 2 * fy * fy * fy;
        a = rnd_half_up(s * 16777216 + sx * (t - s), 24);
        b = rnd_half_up(u * 16777216 + sx * (v - u), 24);
        r = rnd_half_up(a * 16777216 + sy * (b - a), 32);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return 16'(r);
    endfunction

    function automatic bit cell_loaded(logic [23:0] px_b, logic [23:0] py_b);
        longint px, py;
        int cx, cy;
        px = longint'($signed(px_b));
        py = longint'($signed(py_b));
        cx = int'((((px - (px & 255)) / 256) % GW + GW) % GW);
        cy = int'((((py - (py & 255)) / 256) % GH + GH) % GH);
        return grad_written[cx*ROWS+cy] && grad_written[(cx+1)*ROWS+cy] &&
               grad_written[cx*ROWS+cy+1] && grad_written[(cx+1)*ROWS+cy+1];
    endfunction

    task automatic send_beat(t_req item, bit allow_gap);
        int g;
        g = allow_gap ? gap_len() : 0;
        if (g > 0) begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        req_ch.payload <= item;
        req_ch.valid   <= 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if (item.req_type == REQ_WRITE) begin
            if (item.grid_col <= GW && item.grid_row <= GH) begin
                grad_table[item.grid_col*ROWS + item.grid_row] = {item.grad_y, item.grad_x};
                grad_written[item.grid_col*ROWS + item.grid_row] = 1;
            end
        end else begin
            noise_expected = {noise_expected, noise_at(item.point_x, item.point_y)};
            query_count++;
        end
    endtask

    task automatic write_grad(int col, int row, logic [15:0] gx, logic [15:0] gy, bit gap);
        t_req it;
        it = '0;
        it.req_type = REQ_WRITE;
        it.grid_col = col[8:0];
        it.grid_row = row[8:0];
        it.grad_x = gx;
        it.grad_y = gy;
        it.point_x = 24'($urandom);
        it.point_y = 24'($urandom);
        send_beat(it, gap);
    endtask

    task automatic query_point(logic [23:0] px, logic [23:0] py, bit gap);
        t_req it;
        it = '0;
        it.req_type = REQ_QUERY;
        it.grid_col = 9'($urandom);
        it.grid_row = 9'($urandom);
        it.grad_x = 16'($urandom);
        it.grad_y = 16'($urandom);
        it.point_x = px;
        it.point_y = py;
        send_beat(it, gap);
    endtask

    function automatic logic [15:0] rand_grad();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'sd16384;
        if (r == 1) return -16'sd16384;
        if (r == 2) return 16'($urandom);
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    // Point whose cell lies in the loaded corner region cols/rows 0..3 or 253..256.
    function automatic logic [23:0] rand_coord();
        int c;
        c = $urandom_range(0, 5);
        c = (c < 3) ? c : 250 + c;
        c = c + GW * ($urandom_range(0, 255) - 128);
        return 24'(c * 256 + $urandom_range(0, 255));
    endfunction

    task automatic test_extreme_writes();
        // load the four corner regions with extreme gradients
        for (int c = 0; c <= GW; c++) begin
            if (c > 3 && c < 253) continue;
            for (int r = 0; r <= GH; r++) begin
                if (r > 3 && r < 253) continue;
                write_grad(c, r, ((c + r) & 1) ? 16'h8000 : 16'h7fff,
                           (c & 1) ? 16'h7fff : 16'h8000, 0);
            end
        end
        // out-of-table writes are dropped
        write_grad(GW + 1, 0, 16'h1234, 16'h1234, 1);
        write_grad(0, 9'h1ff, 16'h1234, 16'h1234, 1);
        write_grad(9'h1ff, 9'h1ff, 16'hffff, 16'hffff, 1);
    endtask

    task automatic test_directed_queries();
        query_point(24'h000000, 24'h000000, 0);
        query_point(24'h000080, 24'h000080, 0);
        query_point(24'h0000ff, 24'h0000ff, 1);
        query_point(24'h7fffff, 24'h7fffff, 1);
        query_point(24'h800000, 24'h800000, 1);
        query_point(24'hffffff, 24'h000001, 0);
        query_point(24'h00ff40, 24'h00ffc0, 0);
        query_point(24'h010000, 24'hff0000, 1);
        query_point(24'h000201, 24'h0001fe, 1);
    endtask

    task automatic test_random_mix(int n);
        int k, c, r;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 35) begin
                c = $urandom_range(0, 5);
                c = (c < 3) ? c : 250 + c;
                r = $urandom_range(0, 5);
                r = (r < 3) ? r : 250 + r;
                if ($urandom_range(0, 19) == 0) c = $urandom_range(GW + 1, 511);
                write_grad(c, r, rand_grad(), rand_grad(), 1);
            end else begin
                logic [23:0] px, py;
                px = rand_coord();
                py = rand_coord();
                if (!cell_loaded(px, py)) px = 24'($urandom_range(0, 255));
                query_point(px, py, 1);
            end
        end
    endtask

    task automatic drain();
        while (noise_expected.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 0;
        req_ch.valid = 0;
        req_ch.payload = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_extreme_writes();
        test_directed_queries();
        rsp_hold = 1;
        test_random_mix(500);
        rsp_hold = 0;
        test_random_mix(1100);
        req_ch.valid <= 1'b0;
        drain();
        if (error_count == 0) begin
            $display("tb_perlin_gradient_noise_2d: clean");
        end else begin
            $display("tb_perlin_gradient_noise_2d: errors");
        end
        $finish;
    end
endmodule

### perlin_gradient_noise_2d.f
+incdir+sv
sv/pgn_pkg.sv
sv/pgn_if.sv
sv/pgn_front.sv
sv/pgn_back.sv
sv/perlin_gradient_noise_2d.sv
tb/tb_perlin_gradient_noise_2d.sv
